// ===== hw/rtl/text_console_cursor_engine_assert.svh =====
// Assertion macros for the console cursor engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
`timescale 1ns / 1ps

package cce_pkg;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // Result action codes
    localparam logic [1:0] ACT_DRAW   = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GLYPH_WIDTH   = 2'd2;
    localparam logic [1:0] REG_GLYPH_HEIGHT  = 2'd3;

    // Configuration reset values
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [6:0]  RST_GLYPH_WIDTH   = 7'd8;
    localparam logic [6:0]  RST_GLYPH_HEIGHT  = 7'd16;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

    // Classified command kinds
    typedef enum logic [2:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_PRINT
    } op_t;

    // One queued command
    typedef struct packed {
        op_t        op;
        logic [7:0] code;
    } cmd_t;

    // Screen and glyph geometry
    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [6:0]  glyph_width;
        logic [6:0]  glyph_height;
    } geom_t;

endpackage

// ===== hw/rtl/cce_front.sv =====
// Front end: accepts character beats, classifies them and hands them to the queue.
`timescale 1ns / 1ps

module cce_front
    import cce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    cmd_t decoded;
    logic accept;

    // Classify the incoming byte
    always_comb
    begin
        decoded.code = char_code;
        unique case (char_code)
            CHAR_NUL: decoded.op = OP_NOP;
            CHAR_TAB: decoded.op = OP_TAB;
            CHAR_LF:  decoded.op = OP_NEWLINE;
            CHAR_CR:  decoded.op = OP_RETURN;
            default:  decoded.op = OP_PRINT;
        endcase
    end

    // Holding register drains into the queue
    assign in_ready   = !hold_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = decoded;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

// ===== hw/rtl/cce_queue.sv =====
// Short command queue between the front end and the sequencer.
`timescale 1ns / 1ps

module cce_queue
    import cce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/cce_back.sv =====
// Back end: cursor state, command sequencer and output register.
`timescale 1ns / 1ps

module cce_back
    import cce_pkg::*;
#(
    parameter int TAB_COLUMNS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic [7:0]  glyph_code,
    output logic        last
);

    localparam int PW = (TAB_COLUMNS > 1) ? $clog2(TAB_COLUMNS) : 1;
    localparam int RW = $clog2(TAB_COLUMNS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DRAW   = 2'd1;
    localparam logic [1:0] S_LINE   = 2'd2;
    localparam logic [1:0] S_CURSOR = 2'd3;

    logic [1:0]    state_reg,  state_next;
    logic [11:0]   cx_reg,     cx_next;
    logic [11:0]   cy_reg,     cy_next;
    logic [11:0]   col_reg,    col_next;
    logic [PW-1:0] phase_reg,  phase_next;
    logic [RW-1:0] rem_reg,    rem_next;
    logic [7:0]    glyph_reg,  glyph_next;

    logic          ov_reg,     ov_next;
    logic [1:0]    act_reg,    act_next;
    logic [11:0]   ox_reg,     ox_next;
    logic [11:0]   oy_reg,     oy_next;
    logic [7:0]    oc_reg,     oc_next;
    logic          ol_reg,     ol_next;

    logic          emit_ok;
    logic [12:0]   cx_adv;
    logic [13:0]   edge_sum;
    logic          wrap;
    logic [12:0]   cy_sum;
    logic          scroll;
    logic [RW-1:0] rem_dec;

    assign emit_ok   = !ov_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    // Edge checks: right edge after an advance, bottom edge on a new line
    assign cx_adv   = {1'b0, cx_reg} + {6'b0, geom.glyph_width};
    assign edge_sum = {1'b0, cx_adv} + {7'b0, geom.glyph_width};
    assign wrap     = edge_sum > {2'b0, geom.screen_width};
    assign cy_sum   = {1'b0, cy_reg} + {6'b0, geom.glyph_height};
    assign scroll   = cy_sum >= {1'b0, geom.screen_height};
    assign rem_dec  = rem_reg - RW'(1);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        glyph_next = glyph_reg;
        ov_next    = ov_reg && !out_ready;
        act_next   = act_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    rem_next = '0;
                    unique case (cmd.op)
                        OP_NOP:
                        begin
                            state_next = S_CURSOR;
                        end
                        OP_RETURN:
                        begin
                            cx_next    = '0;
                            col_next   = '0;
                            phase_next = '0;
                            state_next = S_CURSOR;
                        end
                        OP_NEWLINE:
                        begin
                            state_next = S_LINE;
                        end
                        OP_TAB:
                        begin
                            glyph_next = CHAR_SPACE;
                            rem_next   = RW'(TAB_COLUMNS) - RW'(phase_reg);
                            state_next = S_DRAW;
                        end
                        default:
                        begin
                            glyph_next = cmd.code;
                            rem_next   = RW'(1);
                            state_next = S_DRAW;
                        end
                    endcase
                end
            end

            S_DRAW:
            begin
                if (emit_ok)
                begin
                    ov_next  = 1'b1;
                    act_next = ACT_DRAW;
                    ox_next  = cx_reg;
                    oy_next  = cy_reg;
                    oc_next  = glyph_reg;
                    ol_next  = 1'b0;
                    col_next = col_reg + 12'd1;
                    // Tab phase tracks the column count modulo the tab stop
                    if (col_reg == 12'hFFF || phase_reg == PW'(TAB_COLUMNS - 1))
                    begin
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + PW'(1);
                    end
                    rem_next = rem_dec;
                    if (wrap)
                    begin
                        cx_next    = '0;
                        state_next = S_LINE;
                    end
                    else
                    begin
                        cx_next    = cx_adv[11:0];
                        state_next = (rem_dec == '0) ? S_CURSOR : S_DRAW;
                    end
                end
            end

            S_LINE:
            begin
                if (emit_ok)
                begin
                    cx_next    = '0;
                    col_next   = '0;
                    phase_next = '0;
                    if (scroll)
                    begin
                        ov_next  = 1'b1;
                        act_next = ACT_SCROLL;
                        ox_next  = '0;
                        oy_next  = '0;
                        oc_next  = '0;
                        ol_next  = 1'b0;
                    end
                    else
                    begin
                        cy_next = cy_sum[11:0];
                    end
                    state_next = (rem_reg == '0) ? S_CURSOR : S_DRAW;
                end
            end

            S_CURSOR:
            begin
                if (emit_ok)
                begin
                    ov_next    = 1'b1;
                    act_next   = ACT_CURSOR;
                    ox_next    = cx_reg;
                    oy_next    = cy_reg;
                    oc_next    = '0;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cx_reg    <= '0;
            cy_reg    <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        act_reg   <= act_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oc_reg    <= oc_next;
        ol_reg    <= ol_next;
    end

    assign out_valid  = ov_reg;
    assign action     = act_reg;
    assign pos_x      = ox_reg;
    assign pos_y      = oy_reg;
    assign glyph_code = oc_reg;
    assign last       = ol_reg;

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Path: a character beat passes through the front-end holding register and the command
// queue to the sequencer; its results leave through the output register, ending with a cursor update.
// The sequencer takes a new command only once it is idle again; the holding register and
// queue buffer further bytes meanwhile, and a stalled output holds the sequencer.
// Reset: asynchronous, active low; clears cursor, column count, queue and output valid,
// and loads the geometry registers with 640x480 pixels and 8x16 glyphs.
`timescale 1ns / 1ps

module text_console_cursor_engine
    import cce_pkg::*;
#(
    parameter int TAB_COLUMNS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic [7:0]  glyph_code,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    geom_t geom_reg;
    geom_t geom_next;
    logic  push_valid;
    logic  push_ready;
    cmd_t  push_cmd;
    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;

    // Geometry registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        geom_next = geom_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  geom_next.screen_width  = cfg_data;
                REG_SCREEN_HEIGHT: geom_next.screen_height = cfg_data;
                REG_GLYPH_WIDTH:   geom_next.glyph_width   = cfg_data[6:0];
                REG_GLYPH_HEIGHT:  geom_next.glyph_height  = cfg_data[6:0];
                default:           geom_next = geom_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.screen_width  <= RST_SCREEN_WIDTH;
            geom_reg.screen_height <= RST_SCREEN_HEIGHT;
            geom_reg.glyph_width   <= RST_GLYPH_WIDTH;
            geom_reg.glyph_height  <= RST_GLYPH_HEIGHT;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    cce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    cce_back #(
        .TAB_COLUMNS (TAB_COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .action     (action),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .glyph_code (glyph_code),
        .last       (last)
    );

endmodule

// ===== hw/rtl/cce_checker.sv =====
// Port-level checker for the console cursor engine, bound to the top level.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_assert.svh"

module cce_checker
    import cce_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  char_code,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  action,
    input logic [11:0] pos_x,
    input logic [11:0] pos_y,
    input logic [7:0]  glyph_code,
    input logic        last
);

    // Only the cursor update closes an item, and it carries no glyph
    `CCE_ASSERT_IMPLIES(a_last_is_cursor, clk, rst_n, out_valid && last, action == ACT_CURSOR && glyph_code == 8'd0, "last flag on a result that is not a cursor update")
    `CCE_ASSERT_IMPLIES(a_cursor_is_last, clk, rst_n, out_valid && action == ACT_CURSOR, last, "cursor update without last flag")

    // A scroll carries no position or glyph
    `CCE_ASSERT_IMPLIES(a_scroll_clean, clk, rst_n, out_valid && action == ACT_SCROLL, pos_x == 12'd0 && pos_y == 12'd0 && glyph_code == 8'd0, "scroll result with nonzero fields")

    // A stalled result beat holds
    `CCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action) && $stable(pos_x) && $stable(pos_y) && $stable(glyph_code) && $stable(last), "result beat changed while stalled")

    // A stalled character beat holds
    `CCE_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(char_code), "character beat changed while stalled")

endmodule

bind text_console_cursor_engine cce_checker u_cce_checker (.*);
